// ===== hdl/humidity_temp_frame_decoder_defines.svh =====
`ifndef HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HTFD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("htfd assertion failed");

// next-cycle implication, checked outside reset
`define HTFD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("htfd assertion failed");

`endif

// ===== hdl/htfd_pkg.sv =====
`default_nettype none

package htfd_pkg;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   localparam logic [2:0] COUNT_IDLE      = 3'd0;
   localparam logic [2:0] COUNT_FIRST     = 3'd1;
   localparam logic [2:0] COUNT_LAST_DATA = 3'd5;
   localparam logic [2:0] COUNT_CRC       = 3'd6;

   localparam logic [13:0] HUM_SCALE   = 14'd10000;
   localparam logic [14:0] TEMP_SCALE  = 15'd20000;
   localparam logic [15:0] TEMP_OFFSET = 16'd5000;

   localparam logic CSR_IDX_FRAME_HAS_CRC = 1'b0;

   typedef struct packed {
      logic [19:0] humidity_raw;
      logic [19:0] temperature_raw;
      logic        frame_status;
   } htfd_frame_type;

   function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/htfd_frame.sv =====
`default_nettype none

module htfd_frame (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    frame_has_crc,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [7:0]              rx_byte,
   input  wire logic                    frame_start,
   output logic                         frame_valid,
   input  wire logic                    frame_ready,
   output htfd_pkg::htfd_frame_type     frame_data
);
   import htfd_pkg::*;

   logic [2:0]     count_ff, count_in;
   logic [7:0]     crc_ff, crc_in;
   logic [39:0]    data_ff, data_in;
   logic           valid_ff, valid_in;
   htfd_frame_type frame_ff, frame_in;
   logic           accept;
   logic           done;
   logic           status;
   logic [39:0]    emit_data;

   assign req_ready = !valid_ff || frame_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      count_in  = count_ff;
      crc_in    = crc_ff;
      data_in   = data_ff;
      done      = 1'b0;
      status    = 1'b0;
      emit_data = data_ff;
      if (frame_start) begin
         crc_in   = crc_update(CRC_INIT, rx_byte);
         data_in  = '0;
         count_in = COUNT_FIRST;
      end else begin
         case (count_ff) inside
            [COUNT_FIRST:COUNT_LAST_DATA]: begin
               crc_in  = crc_update(crc_ff, rx_byte);
               data_in = {data_ff[31:0], rx_byte};
               if (count_ff == COUNT_LAST_DATA) begin
                  if (frame_has_crc) begin
                     count_in = COUNT_CRC;
                  end else begin
                     done      = 1'b1;
                     emit_data = {data_ff[31:0], rx_byte};
                     count_in  = COUNT_IDLE;
                     crc_in    = CRC_INIT;
                  end
               end else begin
                  count_in = count_ff + 3'd1;
               end
            end
            COUNT_CRC: begin
               done     = 1'b1;
               status   = (crc_ff != rx_byte);
               count_in = COUNT_IDLE;
               crc_in   = CRC_INIT;
            end
            default: begin
               count_in = COUNT_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      frame_in = frame_ff;
      if (valid_ff && frame_ready) begin
         valid_in = 1'b0;
      end
      if (accept && done) begin
         valid_in                 = 1'b1;
         frame_in.humidity_raw    = emit_data[39:20];
         frame_in.temperature_raw = emit_data[19:0];
         frame_in.frame_status    = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_IDLE;
         crc_ff   <= CRC_INIT;
         data_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
            crc_ff   <= crc_in;
            data_ff  <= data_in;
         end
         valid_ff <= valid_in;
      end
      frame_ff <= frame_in;
   end

   assign frame_valid = valid_ff;
   assign frame_data  = frame_ff;

endmodule

`default_nettype wire

// ===== hdl/htfd_conv.sv =====
`default_nettype none

module htfd_conv (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    frame_valid,
   output logic                         frame_ready,
   input  wire htfd_pkg::htfd_frame_type frame_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [19:0]                  rsp_humidity_raw,
   output logic [19:0]                  rsp_temperature_raw,
   output logic [13:0]                  rsp_humidity_centi,
   output logic signed [14:0]           rsp_temperature_centi,
   output logic                         rsp_frame_status
);
   import htfd_pkg::*;

   logic        valid_ff;
   logic        load;
   logic [33:0] hum_prod;
   logic [34:0] temp_prod;
   logic [15:0] temp_diff;

   logic [19:0]        hum_raw_ff;
   logic [19:0]        temp_raw_ff;
   logic [13:0]        hum_centi_ff;
   logic signed [14:0] temp_centi_ff;
   logic               status_ff;

   assign frame_ready = !valid_ff || rsp_ready;
   assign load        = frame_valid && frame_ready;

   assign hum_prod  = {14'd0, frame_data.humidity_raw} * {20'd0, HUM_SCALE};
   assign temp_prod = {15'd0, frame_data.temperature_raw} * {20'd0, TEMP_SCALE};
   assign temp_diff = {1'b0, temp_prod[34:20]} - TEMP_OFFSET;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
      if (load) begin
         hum_raw_ff    <= frame_data.humidity_raw;
         temp_raw_ff   <= frame_data.temperature_raw;
         hum_centi_ff  <= hum_prod[33:20];
         temp_centi_ff <= $signed(temp_diff[14:0]);
         status_ff     <= frame_data.frame_status;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_humidity_raw      = hum_raw_ff;
   assign rsp_temperature_raw   = temp_raw_ff;
   assign rsp_humidity_centi    = hum_centi_ff;
   assign rsp_temperature_centi = temp_centi_ff;
   assign rsp_frame_status      = status_ff;

endmodule

`default_nettype wire

// ===== hdl/humidity_temp_frame_decoder.sv =====
// a reply's result is held in the frame register once its last request is accepted, then moves to the output register
// throughput: one request per cycle, one result per reply, stalls only on rsp_ready
// the frame register and the output register form a two-stage valid/ready pipeline
// reset is synchronous: byte counter idle, crc 0xff, pipeline empty, frame_has_crc set
`default_nettype none
`include "humidity_temp_frame_decoder_defines.svh"

module humidity_temp_frame_decoder (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_rx_byte,
   input  wire logic               req_frame_start,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [19:0]             rsp_humidity_raw,
   output logic [19:0]             rsp_temperature_raw,
   output logic [13:0]             rsp_humidity_centi,
   output logic signed [14:0]      rsp_temperature_centi,
   output logic                    rsp_frame_status,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   import htfd_pkg::*;

   logic           has_crc_ff;
   logic           csr_write;
   logic           frame_valid;
   logic           frame_ready;
   htfd_frame_type frame_data;
   logic           temp_in_range;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         has_crc_ff <= 1'b1;
      end else if (csr_write && (csr_paddr[2] == CSR_IDX_FRAME_HAS_CRC)) begin
         has_crc_ff <= csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_FRAME_HAS_CRC) begin
         csr_prdata = {31'd0, has_crc_ff};
      end
   end

   htfd_frame u_frame (
      .clock         (clock),
      .reset         (reset),
      .frame_has_crc (has_crc_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .rx_byte       (req_rx_byte),
      .frame_start   (req_frame_start),
      .frame_valid   (frame_valid),
      .frame_ready   (frame_ready),
      .frame_data    (frame_data)
   );

   htfd_conv u_conv (
      .clock                 (clock),
      .reset                 (reset),
      .frame_valid           (frame_valid),
      .frame_ready           (frame_ready),
      .frame_data            (frame_data),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_humidity_raw      (rsp_humidity_raw),
      .rsp_temperature_raw   (rsp_temperature_raw),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_frame_status      (rsp_frame_status)
   );

   assign temp_in_range = (rsp_temperature_centi >= -15'sd5000) &&
                          (rsp_temperature_centi <= 15'sd14999);

   `HTFD_ASSERT_NOW(a_stall_blocks_req, frame_valid && !frame_ready, !req_ready)
   `HTFD_ASSERT_NOW(a_hum_range, rsp_valid, rsp_humidity_centi <= 14'd9999)
   `HTFD_ASSERT_NOW(a_temp_range, rsp_valid, temp_in_range)
   `HTFD_ASSERT_NEXT(a_frame_to_rsp, frame_valid && frame_ready, rsp_valid)

endmodule

`default_nettype wire
